// ----- design/assert_macros.svh -----
// Assertion macros shared by the wavetable lookup checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WTLI_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtli check failed");

// Next-cycle implication, disabled while reset is asserted
`define WTLI_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtli check failed");

`endif

// ----- design/wtli_pkg.sv -----
// Shared types, field layout and constants of the wavetable lookup block.
`timescale 1ns / 1ps

package wtli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int LANES       = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_BITS  = 24;

    localparam int IDX_BITS  = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS = PHASE_BITS - IDX_BITS;
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;

    // Input tdata layout, lowest field first
    localparam int WIDX_LSB     = 0;
    localparam int WSAMP_LSB    = WIDX_LSB + IDX_BITS;
    localparam int PHASE_LSB    = WSAMP_LSB + SAMPLE_BITS;
    localparam int IN_USED_BITS = PHASE_LSB + LANES * PHASE_BITS;
    localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

    // Output tdata layout
    localparam int OUT_USED_BITS = LANES * SAMPLE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int MODE_BITS     = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_BITS-1:0]           index_t;
    typedef logic [PHASE_BITS-1:0]         phase_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NONE   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_ZERO   = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    // Per-cycle strobes broadcast to every lane
    typedef struct packed {
        logic wr_en;
        logic ld_a;
        logic ld_b;
    } lane_ctl_t;

endpackage

// ----- design/wtli_lane.sv -----
// One lookup lane: private table copy, pipelined difference multiply and interpolation.
`timescale 1ns / 1ps

module wtli_lane (
    input  logic                clk,
    input  wtli_pkg::lane_ctl_t ctl,
    input  wtli_pkg::index_t    wr_index,
    input  wtli_pkg::sample_t   wr_sample,
    input  wtli_pkg::phase_t    phase,
    input  wtli_pkg::mode_t     mode,
    output wtli_pkg::sample_t   sample
);
    import wtli_pkg::*;

    sample_t                      mem [TABLE_DEPTH];
    index_t                       idx;
    index_t                       nidx;
    sample_t                      bot_reg;
    sample_t                      top_reg;
    logic [FRAC_BITS-1:0]         frac_reg;
    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  prod_reg;
    sample_t                      bot_b_reg;
    logic signed [PROD_BITS-1:0]  step;
    sample_t                      interp;

    // Split phase into table index and fraction; next entry wraps to zero
    assign idx  = phase[PHASE_BITS-1:FRAC_BITS];
    assign nidx = (idx == index_t'(TABLE_DEPTH - 1)) ? '0 : idx + index_t'(1);

    // Write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_index] <= wr_sample;
        end
        if (ctl.ld_a)
        begin
            bot_reg  <= mem[idx];
            top_reg  <= mem[nidx];
            frac_reg <= phase[FRAC_BITS-1:0];
        end
    end

    // Scale the difference by the fraction
    assign diff = DIFF_BITS'(top_reg) - DIFF_BITS'(bot_reg);
    assign prod = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, frac_reg}));

    always_ff @(posedge clk)
    begin
        if (ctl.ld_b)
        begin
            prod_reg  <= prod;
            bot_b_reg <= bot_reg;
        end
    end

    // Floor shift, add to bottom entry, select by mode
    assign step   = prod_reg >>> FRAC_BITS;
    assign interp = bot_b_reg + step[SAMPLE_BITS-1:0];

    always_comb
    begin
        case (mode)
            MODE_NONE:   sample = bot_b_reg;
            MODE_LINEAR: sample = interp;
            default:     sample = '0;
        endcase
    end

endmodule

// ----- design/wtli_merge.sv -----
// Output stage: gathers lane samples into one result item and holds it for the sink.
`timescale 1ns / 1ps

module wtli_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  wtli_pkg::sample_t                      samples [wtli_pkg::LANES],
    output logic                                   ready,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [wtli_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);
    import wtli_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic [OUT_DATA_BITS-1:0] data_reg;
    logic [OUT_DATA_BITS-1:0] data_next;

    // Take a new item when the register is empty or being drained
    assign ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        data_next = '0;
        for (int k = 0; k < LANES; k++)
        begin
            data_next[k*SAMPLE_BITS +: SAMPLE_BITS] = samples[k];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

// ----- design/wavetable_lookup_interp.sv -----
// Top level of the four-lane wavetable lookup with linear interpolation.
//
//  port group  | dir | contents
//  ------------+-----+------------------------------------------------------
//  s_axis_*    | in  | table write or four-phase lookup item
//  m_axis_*    | out | four looked-up samples per lookup item
//  apb         | in  | interp_mode register at byte address 0
//
// One item is accepted per cycle unless stalled; a lookup result passes through
// the table read, difference multiply and output registers. Each lane owns a
// copy of the table with two read ports, so all eight reads happen in the same
// cycle. Write items update every copy at acceptance and produce no result.
// Reset clears the valid flags and sets interp_mode to linear; the table is not
// cleared. Each stage moves when the one after it is empty or draining.
`timescale 1ns / 1ps

module wavetable_lookup_interp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] write_index, [25:10] write_sample, [49:26] phase_lane0,
    // [73:50] phase_lane1, [97:74] phase_lane2, [121:98] phase_lane3, rest zero
    input  logic [wtli_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // [0] kind
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] sample_lane0, [31:16] sample_lane1, [47:32] sample_lane2,
    // [63:48] sample_lane3
    output logic [wtli_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wtli_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [wtli_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [wtli_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import wtli_pkg::*;

    mode_t     mode_reg;
    mode_t     mode_next;
    logic      va_reg;
    logic      va_next;
    logic      vb_reg;
    logic      vb_next;
    logic      c_ready;
    logic      a_free;
    logic      b_free;
    logic      accept;
    logic      lookup_acc;
    lane_ctl_t ctl;
    logic      reg_sel;
    sample_t   samples [LANES];

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == '0);

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            mode_next = mode_t'(pwdata[MODE_BITS-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINEAR;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign prdata = reg_sel ? APB_DATA_BITS'(mode_reg) : '0;

    // Stage flow control
    assign b_free        = !vb_reg || c_ready;
    assign a_free        = !va_reg || b_free;
    assign s_axis_tready = a_free;
    assign accept        = s_axis_tvalid && a_free;
    assign lookup_acc    = accept && (kind_t'(s_axis_tuser) == KIND_LOOKUP);

    assign ctl.wr_en = accept && (kind_t'(s_axis_tuser) == KIND_WRITE);
    assign ctl.ld_a  = lookup_acc;
    assign ctl.ld_b  = va_reg && b_free;

    always_comb
    begin
        va_next = va_reg;
        vb_next = vb_reg;
        if (a_free)
        begin
            va_next = lookup_acc;
        end
        if (b_free)
        begin
            vb_next = va_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    // Lanes
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        wtli_lane u_lane (
            .clk       (clk),
            .ctl       (ctl),
            .wr_index  (s_axis_tdata[WIDX_LSB +: IDX_BITS]),
            .wr_sample (s_axis_tdata[WSAMP_LSB +: SAMPLE_BITS]),
            .phase     (s_axis_tdata[PHASE_LSB + k*PHASE_BITS +: PHASE_BITS]),
            .mode      (mode_reg),
            .sample    (samples[k])
        );
    end

    // Merge lane results into the output register
    wtli_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (vb_reg),
        .samples       (samples),
        .ready         (c_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- design/wtli_checker.sv -----
// Port-level checker for the wavetable lookup block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wtli_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [wtli_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wtli_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [wtli_pkg::APB_DATA_BITS-1:0]  pwdata,
    input  logic [wtli_pkg::APB_DATA_BITS-1:0]  prdata
);
    import wtli_pkg::*;

    logic                 mode_sel;
    logic                 mode_wr;
    logic [MODE_BITS-1:0] mode_rd;

    // Decode a write to the mode register
    assign mode_sel = (paddr[APB_ADDR_BITS-1:2] == '0);
    assign mode_wr  = psel && penable && pwrite && mode_sel;
    assign mode_rd  = prdata[MODE_BITS-1:0];

    // A stalled result keeps its valid and its data
    `WTLI_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `WTLI_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // With the output empty the pipeline has room for a new item
    `WTLI_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // A mode write reads back on the next cycle
    `WTLI_ASSERT_NXT(a_mode_readback, mode_wr, !mode_sel || mode_rd == $past(pwdata[1:0]))

endmodule

bind wavetable_lookup_interp wtli_checker u_wtli_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
